/* src/rflt_pkg.sv */
// Shared types, constants and the node merge function of the range flip tree.
package rflt_pkg;

  localparam int LOG_LEAVES = 10;
  localparam int LEAVES     = 1 << LOG_LEAVES;
  localparam int CNT_W      = LOG_LEAVES + 1;
  localparam int ADDR_W     = LOG_LEAVES + 1;
  localparam int NODES      = 1 << ADDR_W;
  localparam int DEP_W      = $clog2(LOG_LEAVES + 1);
  localparam int POS_W      = 11;
  localparam int OP_W       = 2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DEP_W-1:0]  dep_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_FLIP  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_RET
  } st_t;

  typedef struct packed {
    cnt_t zeros;
    cnt_t ones;
    cnt_t up;
    cnt_t down;
  } tally_t;

  // A stored node: its counts and a mark that says its children still owe a flip.
  typedef struct packed {
    tally_t cnt;
    logic   tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic cnt_t max2(input cnt_t a, input cnt_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic tally_t swap_tally(input tally_t t);
    tally_t s;
    s.zeros = t.ones;
    s.ones  = t.zeros;
    s.up    = t.down;
    s.down  = t.up;
    return s;
  endfunction

  function automatic tally_t combine(input tally_t l, input tally_t r);
    tally_t t;
    cnt_t   v;
    t.zeros = l.zeros + r.zeros;
    t.ones  = l.ones + r.ones;
    v = max2(l.up, r.up);
    v = max2(v, t.zeros);
    v = max2(v, t.ones);
    v = max2(v, l.zeros + r.ones);
    v = max2(v, l.up + r.ones);
    v = max2(v, l.zeros + r.up);
    t.up = v;
    v = max2(l.down, r.down);
    v = max2(v, l.ones + r.zeros);
    v = max2(v, l.down + r.zeros);
    v = max2(v, l.ones + r.down);
    v = max2(v, t.zeros);
    v = max2(v, t.ones);
    t.down = v;
    return t;
  endfunction

endpackage

/* src/rflt_if.sv */
// Request and result channel interfaces of the range flip tree.
interface rflt_in_if;
  import rflt_pkg::*;
  logic valid;
  logic ready;
  logic [OP_W-1:0] op;
  pos_t position;
  pos_t range_end;
  logic bit_value;
  modport source(output valid, output op, output position, output range_end,
                 output bit_value, input ready);
  modport sink(input valid, input op, input position, input range_end,
               input bit_value, output ready);
endinterface

interface rflt_out_if;
  import rflt_pkg::*;
  logic valid;
  logic ready;
  cnt_t longest_nondecreasing;
  modport source(output valid, output longest_nondecreasing, input ready);
  modport sink(input valid, input longest_nondecreasing, output ready);
endinterface

/* src/rflt_ram.sv */
// Generic single-port synchronous RAM with a registered read.
module rflt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* src/range_flip_binary_lnds_tree.sv */
// Top level of the range flip tree: lazy segment tree over a binary string.
//
// The block keeps a string of 1024 positions, each empty, zero or one, in a
// segment tree held in one 2048-entry single-port RAM (one record per node:
// zero count, one count, longest non-decreasing and non-increasing lengths,
// and a mark saying the node's children still owe a flip). A write request
// stores a bit, a flip request inverts a range, and a query request returns
// the longest non-decreasing subsequence of the whole string from a copy of
// the root kept in a register; its result is valid the cycle after the query
// is accepted. Writes and flips walk the tree depth first through the single
// RAM port, and every visited node passes through the states read, evaluate
// and write back, then return (the return of a right child also merges both
// children into their parent). A write visits the root and both children on
// each of the ten levels below it, 21 nodes, and no new request is taken
// until its walk is done. A flip visits at most the root, its two children
// and four nodes on each deeper level, 39 nodes; a request that misses the
// tree entirely visits only the root. After reset the block clears all 2048
// RAM entries and takes no request until then. A query result waits in an
// output register, and no new request is taken while an untaken result
// sits there.
module range_flip_binary_lnds_tree (
  input logic       clk,
  input logic       rst_n,
  rflt_in_if.sink   in_ch,
  rflt_out_if.source out_ch
);
  import rflt_pkg::*;

  st_t    state_r, state_nxt;
  addr_t  nd_r, nd_nxt;
  dep_t   dep_r, dep_nxt;
  pos_t   lo_r, lo_nxt;
  pos_t   hi_r, hi_nxt;
  logic   flip_r, flip_nxt;
  logic   bit_r, bit_nxt;
  tally_t ret_r, ret_nxt;
  addr_t  clr_r, clr_nxt;
  cnt_t   root_up_r, root_up_nxt;
  logic   out_valid_r, out_valid_nxt;
  cnt_t   out_data_r, out_data_nxt;

  // Per-depth stacks along the current path: the parent's pending mark and
  // the finished left child waiting for its sibling.
  logic   tag_stk_r [LOG_LEAVES+1];
  tally_t left_stk_r [LOG_LEAVES+1];
  logic   tag_push;
  logic   left_push;

  logic   mem_we;
  addr_t  mem_addr;
  rec_t   mem_wdata;
  rec_t   mem_rdata;

  rec_t   cur;
  logic   pt;
  pos_t   node_be;
  pos_t   node_en;
  addr_t  off;
  dep_t   shamt;
  logic   is_leaf;
  tally_t merged;
  logic   in_acc;

  rflt_ram #(.WIDTH(REC_W), .DEPTH(NODES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Span of the node at index nd_r and depth dep_r in the perfect tree.
  always_comb begin
    off     = nd_r & ((addr_t'(1) << dep_r) - addr_t'(1));
    shamt   = dep_t'(LOG_LEAVES) - dep_r;
    node_be = pos_t'(off << shamt) + pos_t'(1);
    node_en = node_be + (pos_t'(1) << shamt) - pos_t'(1);
    is_leaf = (dep_r == dep_t'(LOG_LEAVES));
    pt      = (dep_r == '0) ? 1'b0 : tag_stk_r[dep_r - dep_t'(1)];
    cur.cnt = pt ? swap_tally(mem_rdata.cnt) : mem_rdata.cnt;
    cur.tag = mem_rdata.tag ^ pt;
    merged  = combine(left_stk_r[dep_r], ret_r);
  end

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.longest_nondecreasing = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    nd_nxt        = nd_r;
    dep_nxt       = dep_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    flip_nxt      = flip_r;
    bit_nxt       = bit_r;
    ret_nxt       = ret_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_addr      = nd_r;
    mem_wdata     = cur;
    tag_push      = 1'b0;
    left_push     = 1'b0;

    case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + addr_t'(1);
        if (clr_r == addr_t'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          nd_nxt  = addr_t'(1);
          dep_nxt = '0;
          lo_nxt  = in_ch.position;
          bit_nxt = in_ch.bit_value;
          case (in_ch.op)
            OP_WRITE: begin
              hi_nxt    = in_ch.position;
              flip_nxt  = 1'b0;
              state_nxt = ST_READ;
            end
            OP_FLIP: begin
              hi_nxt    = in_ch.range_end;
              flip_nxt  = 1'b1;
              state_nxt = ST_READ;
            end
            OP_QUERY: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = root_up_r;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (lo_r > node_en || hi_r < node_be) begin
          // Outside the range: only the inherited flip is settled here.
          mem_we    = 1'b1;
          ret_nxt   = cur.cnt;
          state_nxt = ST_RET;
        end else if (lo_r <= node_be && hi_r >= node_en) begin
          mem_we = 1'b1;
          if (flip_r) begin
            mem_wdata.cnt = swap_tally(cur.cnt);
            mem_wdata.tag = cur.tag ^ !is_leaf;
          end else begin
            mem_wdata.cnt.zeros = cnt_t'(!bit_r);
            mem_wdata.cnt.ones  = cnt_t'(bit_r);
            mem_wdata.cnt.up    = cnt_t'(1);
            mem_wdata.cnt.down  = cnt_t'(1);
            mem_wdata.tag       = 1'b0;
          end
          ret_nxt   = mem_wdata.cnt;
          state_nxt = ST_RET;
        end else begin
          // Partly covered: remember the mark for both children and descend.
          tag_push  = 1'b1;
          nd_nxt    = {nd_r[ADDR_W-2:0], 1'b0};
          dep_nxt   = dep_r + dep_t'(1);
          state_nxt = ST_READ;
        end
      end
      ST_RET: begin
        if (dep_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (!nd_r[0]) begin
          left_push = 1'b1;
          nd_nxt    = nd_r + addr_t'(1);
          state_nxt = ST_READ;
        end else begin
          mem_we        = 1'b1;
          mem_addr      = nd_r >> 1;
          mem_wdata.cnt = merged;
          mem_wdata.tag = 1'b0;
          ret_nxt       = merged;
          nd_nxt        = nd_r >> 1;
          dep_nxt       = dep_r - dep_t'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    root_up_nxt = root_up_r;
    if (mem_we && mem_addr == addr_t'(1)) begin
      root_up_nxt = mem_wdata.cnt.up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      root_up_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      root_up_r   <= root_up_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nd_r       <= nd_nxt;
    dep_r      <= dep_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    flip_r     <= flip_nxt;
    bit_r      <= bit_nxt;
    ret_r      <= ret_nxt;
    out_data_r <= out_data_nxt;
    if (tag_push) begin
      tag_stk_r[dep_r] <= cur.tag;
    end
    if (left_push) begin
      left_stk_r[dep_r] <= ret_r;
    end
  end

endmodule

/* tb/range_flip_binary_lnds_tree_tb.sv */
// Self-checking testbench for the range flip tree: directed table, then random requests.
module range_flip_binary_lnds_tree_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rflt_pkg::*;

  // The one op code that the package leaves unnamed; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  rflt_in_if  in_ch();
  rflt_out_if out_ch();

  range_flip_binary_lnds_tree dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the string: one occupied flag and one bit per position.
  logic str_used [1:LEAVES];
  logic str_bit  [1:LEAVES];

  // Query answers still owed by the block, oldest first.
  cnt_t lnds_pending[$];

  int errors      = 0;
  int send_idle   = 0;
  int recv_stall  = 0;

  typedef struct {
    logic [OP_W-1:0] op;
    int              pos;
    int              last;
    logic            bitv;
    bit              typed;
    int              answer;
  } row_t;

  // Directed rows. Where typed is set, the answer is written out by hand;
  // all other rows go through the predictor.
  row_t dir_rows[] = '{
    '{OP_QUERY,     1,    1, 1'b0, 1, 0},    // empty string right after reset
    '{OP_FLIP,      1, 1024, 1'b0, 0, 0},    // flipping empty positions does nothing
    '{OP_QUERY,     1,    1, 1'b0, 1, 0},
    '{OP_WRITE,     1,    1, 1'b1, 0, 0},    // lowest position
    '{OP_QUERY,     1,    1, 1'b0, 1, 1},
    '{OP_WRITE,  1024,    1, 1'b0, 0, 0},    // highest position
    '{OP_QUERY,     1,    1, 1'b0, 1, 1},    // string 1,0
    '{OP_FLIP,      1, 1024, 1'b0, 0, 0},    // whole range
    '{OP_QUERY,     1,    1, 1'b0, 1, 2},    // string 0,1
    '{OP_WRITE,     0,    1, 1'b1, 0, 0},    // position zero is dropped
    '{OP_WRITE,  2047,    1, 1'b1, 0, 0},    // far above the string, dropped
    '{OP_WRITE,  1025,    1, 1'b1, 0, 0},
    '{OP_QUERY,     1,    1, 1'b0, 1, 2},
    '{OP_FLIP,      0, 2047, 1'b0, 0, 0},    // range reaches past both ends
    '{OP_QUERY,     1,    1, 1'b0, 1, 1},    // string 1,0
    '{OP_FLIP,      9,    3, 1'b1, 0, 0},    // empty range
    '{OP_UNUSED,    1, 1024, 1'b1, 0, 0},    // unknown op
    '{OP_QUERY,     1,    1, 1'b0, 1, 1},
    '{OP_FLIP,      1,    1, 1'b0, 0, 0},    // single position
    '{OP_QUERY,     1,    1, 1'b0, 1, 2},
    '{OP_WRITE,   512,    1, 1'b1, 0, 0},
    '{OP_FLIP,    300,  700, 1'b0, 0, 0},
    '{OP_FLIP,    513, 1500, 1'b0, 0, 0},
    '{OP_QUERY, 11'h7ff, 11'h7ff, 1'b1, 0, 0}
  };

  // Longest non-decreasing subsequence of the shadow string: the best split
  // takes every zero before it and every one after it.
  function automatic cnt_t longest_run_up();
    int ones_total;
    int zeros_seen;
    int ones_seen;
    int best;
    ones_total = 0;
    for (int i = 1; i <= LEAVES; i++) begin
      if (str_used[i] && str_bit[i]) ones_total++;
    end
    best = ones_total;
    zeros_seen = 0;
    ones_seen = 0;
    for (int i = 1; i <= LEAVES; i++) begin
      if (str_used[i]) begin
        if (str_bit[i]) ones_seen++;
        else zeros_seen++;
        if (zeros_seen + ones_total - ones_seen > best) begin
          best = zeros_seen + ones_total - ones_seen;
        end
      end
    end
    return cnt_t'(best);
  endfunction

  // Applies one accepted request to the shadow string and, for a query,
  // returns the expected answer through has_answer/answer.
  task automatic apply_request(input logic [OP_W-1:0] op, input int pos, input int last,
                               input logic bitv, output bit has_answer,
                               output cnt_t answer);
    int lo;
    int hi;
    has_answer = 0;
    answer = '0;
    case (op)
      OP_WRITE: begin
        if (pos >= 1 && pos <= LEAVES) begin
          str_used[pos] = 1'b1;
          str_bit[pos]  = bitv;
        end
      end
      OP_FLIP: begin
        lo = (pos < 1) ? 1 : pos;
        hi = (last > LEAVES) ? LEAVES : last;
        for (int i = lo; i <= hi; i++) begin
          str_bit[i] = ~str_bit[i];
        end
      end
      OP_QUERY: begin
        has_answer = 1;
        answer = longest_run_up();
      end
      default: ;
    endcase
  endtask

  // Presents one request and holds it until the block takes it. Entered and
  // left at a rising edge, so back-to-back calls keep valid high with a
  // single assignment per edge. Before a request the sender may idle, and
  // goes on idling while each draw falls under the phase's idle probability.
  task automatic send_request(input logic [OP_W-1:0] op, input int pos, input int last,
                              input logic bitv, input bit typed, input int typed_answer);
    bit   has_answer;
    cnt_t answer;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.position  <= pos_t'(pos);
    in_ch.range_end <= pos_t'(last);
    in_ch.bit_value <= bitv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_request(op, pos, last, bitv, has_answer, answer);
    if (has_answer) begin
      // A typed answer stands in for the predictor on the rows that carry one.
      lnds_pending.push_back(typed ? cnt_t'(typed_answer) : answer);
    end
  endtask

  // Mostly in-range positions, now and then zero or somewhere up to the top
  // of the 11-bit field so that every bit toggles.
  function automatic int pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 0;
    if (r < 8) return $urandom_range(LEAVES + 1, 2047);
    if (r < 15) return (r < 11) ? 1 : LEAVES;
    return $urandom_range(1, LEAVES);
  endfunction

  task automatic random_request();
    int   r;
    int   pos;
    int   last;
    r = $urandom_range(99);
    pos = pick_position();
    if (r < 40) begin
      send_request(OP_WRITE, pos, $urandom_range(0, 2047), 1'($urandom), 0, 0);
    end else if (r < 70) begin
      // Flip widths are short, medium or long; a few ranges are reversed.
      case ($urandom_range(3))
        0: last = pos + $urandom_range(0, 8);
        1: last = pos + $urandom_range(0, 300);
        2: last = pick_position();
        default: last = $urandom_range(pos, 2047);
      endcase
      if (last > 2047) last = 2047;
      send_request(OP_FLIP, pos, last, 1'($urandom), 0, 0);
    end else if (r < 95) begin
      send_request(OP_QUERY, pos, $urandom_range(0, 2047), 1'($urandom), 0, 0);
    end else begin
      send_request(OP_UNUSED, pos, $urandom_range(0, 2047), 1'($urandom), 0, 0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random back-pressure and an in-order check of each answer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (lnds_pending.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   out_ch.longest_nondecreasing);
          errors++;
        end else begin
          if (out_ch.longest_nondecreasing !== lnds_pending[0]) begin
            $display("%0t: longest_nondecreasing mismatch, expected %0d, actual %0d",
                     $time, lnds_pending[0], out_ch.longest_nondecreasing);
            errors++;
          end
          void'(lnds_pending.pop_front());
        end
      end
      out_ch.ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    end
  end

  // Stimulus: reset, the directed table, a full drain, then four random phases.
  initial begin
    int phase_send [4];
    int phase_recv [4];
    int per_phase;
    phase_send = '{0, 64, 0, 35};
    phase_recv = '{0, 0, 64, 35};
    for (int i = 1; i <= LEAVES; i++) begin
      str_used[i] = 1'b0;
      str_bit[i]  = 1'b0;
    end
    rst_n <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_WRITE;
    in_ch.position  <= '0;
    in_ch.range_end <= '0;
    in_ch.bit_value <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].last, dir_rows[i].bitv,
                   dir_rows[i].typed, dir_rows[i].answer);
    end

    // Hold off until every answer owed so far has come back.
    in_ch.valid <= 1'b0;
    while (lnds_pending.size() != 0) @(posedge clk);

    per_phase = 430;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = phase_send[ph];
      recv_stall = phase_recv[ph];
      for (int n = 0; n < per_phase; n++) begin
        random_request();
      end
    end
    in_ch.valid <= 1'b0;
    recv_stall = 0;

    while (lnds_pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, clearing pass included.
  initial begin
    #60ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
